// ===== hdl/ddo_pkg.sv =====
// ddo_pkg: shared types, constants and the arctangent table of the odometry core
// no dependencies; used by every other file of the block
`default_nettype none

package ddo_pkg;

  localparam int CntW     = 32;
  localparam int TimeW    = 20;
  localparam int DistW    = 32;
  localparam int AngW     = 31;
  localparam int PosW     = 48;
  localparam int HeadW    = 32;
  localparam int SpdW     = 32;
  localparam int RateW    = 48;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam int StageW   = 5;
  localparam int StepCntW = 6;

  localparam logic [CfgIdxW-1:0] RegDist  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAngle = 2'd1;

  localparam logic [DistW-1:0] DistReset  = 32'd2697000;
  localparam logic [AngW-1:0]  AngReset   = 31'd1431655;
  localparam logic [31:0]      UsecPerSec = 32'd1000000;
  localparam logic [33:0]      CordicGain = 34'd652032874;

  // quotient lengths of the two divisions
  localparam int SpdSteps  = 32;
  localparam int RateSteps = 48;

  typedef struct packed {
    logic signed [CntW-1:0] left_count;
    logic signed [CntW-1:0] right_count;
    logic [TimeW-1:0]       step_time;
  } in_item_t;

  typedef struct packed {
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
    logic signed [HeadW-1:0] heading;
    logic signed [SpdW-1:0]  linear_speed;
    logic signed [RateW-1:0] turn_rate;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_M,
    OP_MUL_T,
    OP_NS_LO,
    OP_NS_HI,
    OP_DIVS_INIT,
    OP_DIV_STEP,
    OP_SPD,
    OP_X_HI,
    OP_X_LO,
    OP_Y_HI,
    OP_Y_LO,
    OP_ACC,
    OP_NT_LO,
    OP_NT_HI,
    OP_DIVT_INIT,
    OP_RATE,
    OP_OUT
  } ddo_op_e;

  typedef struct packed {
    ddo_op_e           op;
    logic              cordic_step;
    logic [StageW-1:0] stage;
  } ddo_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ddo_status_t;

  // rounded atan(2^-i) in binary angle units
  function automatic logic [31:0] ddo_atan(input logic [StageW-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ddo_if.sv =====
// ddo_if: valid/ready channel interfaces for encoder items and pose items
// depends on ddo_pkg for the payload types
`default_nettype none

interface ddo_in_if;
  logic              valid;
  logic              ready;
  ddo_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  ddo_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/diff_drive_odometry_core.sv =====
// diff_drive_odometry_core: top level of the differential-drive odometry block
// depends on ddo_pkg, ddo_if, ddo_ctrl and ddo_datapath
`default_nettype none

// Takes one item of cumulative left/right encoder counts plus elapsed time in
// microseconds and returns one pose item: x/y position in 2^-16 m (saturating),
// heading as a 32-bit binary angle, centre speed in 2^-16 m/s and turn rate in
// binary angle units per second (both zero when the elapsed time is zero). The
// position step uses the heading at the middle of the update. The result is
// offered from the result register, and the block takes the next item only after
// that register is loaded, which waits while an earlier result is still held; the
// work goes through the shared 33x32 multiplier (ten products) and the
// one-bit-per-cycle divider (32 quotient bits for speed, 48 for turn rate). The rotator runs its
// CORDIC_STAGES iterations (at most 32) alongside the speed division. The
// configuration registers (0: distance per tick, 1: heading change per tick
// difference) are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while the
// block is idle, which the block itself does not enforce; writes to other indexes are ignored.
module diff_drive_odometry_core #(
  parameter int CORDIC_STAGES = 24
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [ddo_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [ddo_pkg::CfgDataW-1:0]  cfg_data_i,
  ddo_in_if.sink                       in_i,
  ddo_out_if.source                    out_o
);
  import ddo_pkg::*;

  ddo_cmd_t    cmd;
  ddo_status_t status;

  // sequencer: accepts an item in idle and steps the datapath through it
  ddo_ctrl #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic, pose state and the result register
  ddo_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

`default_nettype wire

// ===== hdl/ddo_ctrl.sv =====
// ddo_ctrl: sequencer that walks the datapath through one odometry update
// depends on ddo_pkg for the command and status types
`default_nettype none

module ddo_ctrl #(
  parameter int CORDIC_STAGES = 24
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  ddo_pkg::ddo_status_t status_i,
  output ddo_pkg::ddo_cmd_t    cmd_o
);
  import ddo_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_M, S_MUL_T, S_NS_LO, S_NS_HI, S_DIVS_INIT, S_DIVS, S_SPD,
    S_X_HI, S_X_LO, S_Y_HI, S_Y_LO, S_ACC, S_NT_LO, S_NT_HI, S_DIVT_INIT,
    S_DIVT, S_RATE, S_OUT
  } state_e;

  state_e                state_q;
  logic [StepCntW-1:0]   cnt_q;
  logic                  ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_MUL_M;
            ready_q <= 1'b0;
          end
        end
        S_MUL_M:     state_q <= S_MUL_T;
        S_MUL_T:     state_q <= S_NS_LO;
        S_NS_LO:     state_q <= S_NS_HI;
        S_NS_HI:     state_q <= S_DIVS_INIT;
        S_DIVS_INIT: begin
          state_q <= S_DIVS;
          cnt_q   <= '0;
        end
        S_DIVS: begin
          if (cnt_q == StepCntW'(SpdSteps - 1)) begin
            state_q <= S_SPD;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SPD:       state_q <= S_X_HI;
        S_X_HI:      state_q <= S_X_LO;
        S_X_LO:      state_q <= S_Y_HI;
        S_Y_HI:      state_q <= S_Y_LO;
        S_Y_LO:      state_q <= S_ACC;
        S_ACC:       state_q <= S_NT_LO;
        S_NT_LO:     state_q <= S_NT_HI;
        S_NT_HI:     state_q <= S_DIVT_INIT;
        S_DIVT_INIT: begin
          state_q <= S_DIVT;
          cnt_q   <= '0;
        end
        S_DIVT: begin
          if (cnt_q == StepCntW'(RateSteps - 1)) begin
            state_q <= S_RATE;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_RATE:      state_q <= S_OUT;
        S_OUT: begin
          if (!status_i.out_busy) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = ready_q;

  always_comb begin
    cmd_o             = '0;
    cmd_o.op          = OP_NONE;
    cmd_o.stage       = cnt_q[StageW-1:0];
    cmd_o.cordic_step = (state_q == S_DIVS) && (int'(cnt_q) < CORDIC_STAGES);
    case (state_q)
      S_IDLE:      cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_MUL_M:     cmd_o.op = OP_MUL_M;
      S_MUL_T:     cmd_o.op = OP_MUL_T;
      S_NS_LO:     cmd_o.op = OP_NS_LO;
      S_NS_HI:     cmd_o.op = OP_NS_HI;
      S_DIVS_INIT: cmd_o.op = OP_DIVS_INIT;
      S_DIVS:      cmd_o.op = OP_DIV_STEP;
      S_SPD:       cmd_o.op = OP_SPD;
      S_X_HI:      cmd_o.op = OP_X_HI;
      S_X_LO:      cmd_o.op = OP_X_LO;
      S_Y_HI:      cmd_o.op = OP_Y_HI;
      S_Y_LO:      cmd_o.op = OP_Y_LO;
      S_ACC:       cmd_o.op = OP_ACC;
      S_NT_LO:     cmd_o.op = OP_NT_LO;
      S_NT_HI:     cmd_o.op = OP_NT_HI;
      S_DIVT_INIT: cmd_o.op = OP_DIVT_INIT;
      S_DIVT:      cmd_o.op = OP_DIV_STEP;
      S_RATE:      cmd_o.op = OP_RATE;
      S_OUT:       cmd_o.op = status_i.out_busy ? OP_NONE : OP_OUT;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/ddo_datapath.sv =====
// ddo_datapath: registers, shared multiplier, cordic rotator, divider and result register
// depends on ddo_pkg; driven by ddo_ctrl commands
`default_nettype none

module ddo_datapath (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [ddo_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire [ddo_pkg::CfgDataW-1:0]        cfg_data_i,
  input  ddo_pkg::in_item_t                  in_data_i,
  input  ddo_pkg::ddo_cmd_t                  cmd_i,
  output ddo_pkg::ddo_status_t               status_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output ddo_pkg::out_item_t                 out_data_o
);
  import ddo_pkg::*;

  // configuration and persistent state
  logic [DistW-1:0]        dist_q;
  logic [AngW-1:0]         ang_q;
  logic [CntW-1:0]         prev_l_q, prev_r_q;
  logic signed [PosW-1:0]  acc_x_q, acc_y_q;
  logic [HeadW-1:0]        acc_h_q;

  // per-item working registers
  logic [TimeW-1:0]        dt_q;
  logic                    sneg_q, tneg_q;
  logic [32:0]             smag_q, dmag_q;
  logic [63:0]             mag_q, tmag_q;
  logic [83:0]             num_q;
  logic [TimeW-1:0]        rem_q;
  logic [47:0]             dq_q;
  logic                    ovf_q;
  logic signed [33:0]      x_q, y_q, z_q;
  logic                    flip_q;
  logic [63:0]             pa_q;
  logic signed [49:0]      dx_q, dy_q;
  logic signed [SpdW-1:0]  spd_q;
  logic signed [RateW-1:0] rate_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;

  // rotator outputs and their magnitudes
  logic signed [33:0] cos_v, sin_v;
  logic               cneg, sneg_trig;
  logic [33:0]        cabs_w, sabs_w;

  always_comb begin
    cos_v     = flip_q ? -x_q : x_q;
    sin_v     = flip_q ? -y_q : y_q;
    cneg      = cos_v[33];
    sneg_trig = sin_v[33];
    cabs_w    = cneg ? 34'(-cos_v) : 34'(cos_v);
    sabs_w    = sneg_trig ? 34'(-sin_v) : 34'(sin_v);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_M: begin mul_a = smag_q; mul_b = dist_q; end
      OP_MUL_T: begin mul_a = dmag_q; mul_b = {1'b0, ang_q}; end
      OP_NS_LO: begin mul_a = {1'b0, mag_q[31:0]};  mul_b = UsecPerSec; end
      OP_NS_HI: begin mul_a = {1'b0, mag_q[63:32]}; mul_b = UsecPerSec; end
      OP_NT_LO: begin mul_a = {1'b0, tmag_q[31:0]};  mul_b = UsecPerSec; end
      OP_NT_HI: begin mul_a = {1'b0, tmag_q[63:32]}; mul_b = UsecPerSec; end
      OP_X_HI:  begin mul_a = {1'b0, mag_q[63:32]}; mul_b = cabs_w[31:0]; end
      OP_X_LO:  begin mul_a = {1'b0, mag_q[31:0]};  mul_b = cabs_w[31:0]; end
      OP_Y_HI:  begin mul_a = {1'b0, mag_q[63:32]}; mul_b = sabs_w[31:0]; end
      OP_Y_LO:  begin mul_a = {1'b0, mag_q[31:0]};  mul_b = sabs_w[31:0]; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
    prod = {32'b0, mul_a} * {33'b0, mul_b};
  end

  // encoder deltas
  logic [CntW-1:0]    dl_w, dr_w;
  logic signed [32:0] sum_w, diff_w;

  always_comb begin
    dl_w   = in_data_i.left_count - prev_l_q;
    dr_w   = in_data_i.right_count - prev_r_q;
    sum_w  = {dl_w[31], dl_w} + {dr_w[31], dr_w};
    diff_w = {dr_w[31], dr_w} - {dl_w[31], dl_w};
  end

  // signed heading change and midpoint angle
  logic [63:0] dth_w;
  logic [31:0] mid_w;
  logic        flip_w;
  logic [31:0] rot_w;

  always_comb begin
    dth_w  = tneg_q ? -tmag_q : tmag_q;
    mid_w  = acc_h_q + dth_w[32:1];
    flip_w = mid_w[31] ^ mid_w[30];
    rot_w  = {mid_w[31] ^ flip_w, mid_w[30:0]};
  end

  // one rotator stage
  logic signed [33:0] xs_w, ys_w, at_w;

  always_comb begin
    xs_w = x_q >>> cmd_i.stage;
    ys_w = y_q >>> cmd_i.stage;
    at_w = signed'({2'b00, ddo_atan(cmd_i.stage)});
  end

  // one divider step
  logic [TimeW:0] dtrial_w;
  logic           dge_w;

  always_comb begin
    dtrial_w = {rem_q, dq_q[47]};
    dge_w    = dtrial_w >= {1'b0, dt_q};
  end

  // rounded displacement magnitude
  logic [63:0]        rsum_w;
  logic [48:0]        rmag_w;

  always_comb begin
    rsum_w = pa_q + 64'd16384 + {32'b0, prod[63:32]};
    rmag_w = rsum_w[63:15];
  end

  // saturating pose update
  logic signed [49:0] nx_w, ny_w;
  logic signed [PosW-1:0] satx_w, saty_w;

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [49:0] v);
    logic signed [PosW-1:0] r;
    if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
      r = v[PosW-1:0];
    end else if (v[49]) begin
      r = {1'b1, {(PosW-1){1'b0}}};
    end else begin
      r = {1'b0, {(PosW-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    nx_w   = {{2{acc_x_q[PosW-1]}}, acc_x_q} + dx_q;
    ny_w   = {{2{acc_y_q[PosW-1]}}, acc_y_q} + dy_q;
    satx_w = sat_pos(nx_w);
    saty_w = sat_pos(ny_w);
  end

  // rate finishing
  logic [31:0]        spd_lim_w, spd_m_w;
  logic [47:0]        rate_lim_w, rate_m_w;

  always_comb begin
    spd_lim_w  = sneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    spd_m_w    = (ovf_q || dq_q[31:0] > spd_lim_w) ? spd_lim_w : dq_q[31:0];
    rate_lim_w = tneg_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    rate_m_w   = (ovf_q || dq_q > rate_lim_w) ? rate_lim_w : dq_q;
  end

  // control-side state: configuration, accumulators, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q      <= DistReset;
      ang_q       <= AngReset;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_h_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDist:  dist_q <= cfg_data_i;
          RegAngle: ang_q  <= cfg_data_i[AngW-1:0];
          default:  ;
        endcase
      end
      if (cmd_i.op == OP_LOAD) begin
        prev_l_q <= in_data_i.left_count;
        prev_r_q <= in_data_i.right_count;
      end
      if (cmd_i.op == OP_ACC) begin
        acc_x_q <= satx_w;
        acc_y_q <= saty_w;
        acc_h_q <= acc_h_q + dth_w[31:0];
      end
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        dt_q   <= in_data_i.step_time;
        sneg_q <= sum_w[32];
        tneg_q <= diff_w[32];
        smag_q <= sum_w[32] ? 33'(-sum_w) : 33'(sum_w);
        dmag_q <= diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
      end
      OP_MUL_M: mag_q  <= prod[63:0];
      OP_MUL_T: tmag_q <= prod[63:0];
      OP_NS_LO, OP_NT_LO: num_q <= {32'b0, prod[51:0]};
      OP_NS_HI, OP_NT_HI: num_q <= num_q + {prod[51:0], 32'b0};
      OP_DIVS_INIT: begin
        // quotient of (num / 2^17) / dt, 32 bits, overflow when it cannot fit
        ovf_q  <= num_q[83:49] >= {15'b0, dt_q};
        rem_q  <= num_q[68:49];
        dq_q   <= {num_q[48:17], 16'b0};
        x_q    <= signed'(CordicGain);
        y_q    <= '0;
        z_q    <= signed'({{2{rot_w[31]}}, rot_w});
        flip_q <= flip_w;
      end
      OP_DIVT_INIT: begin
        ovf_q <= num_q[83:48] >= {16'b0, dt_q};
        rem_q <= num_q[67:48];
        dq_q  <= num_q[47:0];
      end
      OP_DIV_STEP: begin
        rem_q <= dge_w ? TimeW'(dtrial_w - {1'b0, dt_q}) : dtrial_w[TimeW-1:0];
        dq_q  <= {dq_q[46:0], dge_w};
        if (cmd_i.cordic_step) begin
          if (!z_q[33]) begin
            x_q <= x_q - ys_w;
            y_q <= y_q + xs_w;
            z_q <= z_q - at_w;
          end else begin
            x_q <= x_q + ys_w;
            y_q <= y_q - xs_w;
            z_q <= z_q + at_w;
          end
        end
      end
      OP_SPD: begin
        if (dt_q == '0) spd_q <= '0;
        else spd_q <= sneg_q ? signed'(-spd_m_w) : signed'(spd_m_w);
      end
      OP_RATE: begin
        if (dt_q == '0) rate_q <= '0;
        else rate_q <= tneg_q ? signed'(-rate_m_w) : signed'(rate_m_w);
      end
      OP_X_HI, OP_Y_HI: pa_q <= prod[63:0];
      OP_X_LO: dx_q <= (sneg_q ^ cneg) ? -signed'({1'b0, rmag_w})
                                       : signed'({1'b0, rmag_w});
      OP_Y_LO: dy_q <= (sneg_q ^ sneg_trig) ? -signed'({1'b0, rmag_w})
                                            : signed'({1'b0, rmag_w});
      OP_OUT: begin
        out_q.pos_x        <= acc_x_q;
        out_q.pos_y        <= acc_y_q;
        out_q.heading      <= signed'(acc_h_q);
        out_q.linear_speed <= spd_q;
        out_q.turn_rate    <= rate_q;
      end
      default: ;
    endcase
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

// ===== hdl/ddo_checker.sv =====
// ddo_checker: port-level assertions for the odometry core, bound to the top level
// depends on ddo_pkg and diff_drive_odometry_core
`default_nettype none

module ddo_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_i,
  input wire                out_valid_i,
  input wire                out_ready_i,
  input ddo_pkg::out_item_t out_data_i
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed or dropped while stalled");

  // an accepted item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still ready right after an item was taken");

  // a new result only comes out of a busy block
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without an item in work");

  // a result never first appears straight after an item is taken
  a_no_accept_on_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared right after an item was taken");

endmodule

bind diff_drive_odometry_core ddo_checker u_ddo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
